>>> sv/wstd_pkg.sv
`default_nettype none
package wstd_pkg;

	localparam int WORKERS_DEF        = 8;
	localparam int DEQUE_DEPTH_DEF    = 64;
	localparam int OVERFLOW_DEPTH_DEF = 128;
	localparam int ID_WIDTH_DEF       = 32;

	localparam int ID_FIELD_W = 32;
	localparam int WORKER_W   = 3;
	localparam int ORIGIN_W   = 2;
	localparam int VICTIM_W   = 3;
	localparam int AW_W       = 4;

	localparam logic [AW_W-1:0] AW_RESET = 4'd8;

	localparam logic CMD_POST  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	localparam logic [ORIGIN_W-1:0] ORG_DEQUE    = 2'd0;
	localparam logic [ORIGIN_W-1:0] ORG_OVERFLOW = 2'd1;
	localparam logic [ORIGIN_W-1:0] ORG_FULL     = 2'd2;
	localparam logic [ORIGIN_W-1:0] ORG_BAD      = 2'd3;
	localparam logic [ORIGIN_W-1:0] ORG_OWN      = 2'd0;
	localparam logic [ORIGIN_W-1:0] ORG_STOLEN   = 2'd1;
	localparam logic [ORIGIN_W-1:0] ORG_FIFO     = 2'd2;
	localparam logic [ORIGIN_W-1:0] ORG_NONE     = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		SRC_NONE,
		SRC_DEQUE,
		SRC_FIFO
	} src_t;

endpackage
`default_nettype wire

>>> sv/wstd_in_if.sv
`default_nettype none
interface wstd_in_if;
	logic                            valid;
	logic                            ready;
	logic                            command;
	logic [wstd_pkg::WORKER_W-1:0]   worker;
	logic [wstd_pkg::ID_FIELD_W-1:0] post_id;

	modport source (output valid, command, worker, post_id, input ready);
	modport sink (input valid, command, worker, post_id, output ready);
endinterface
`default_nettype wire

>>> sv/wstd_out_if.sv
`default_nettype none
interface wstd_out_if;
	logic                            valid;
	logic                            ready;
	logic                            ok;
	logic [wstd_pkg::ID_FIELD_W-1:0] task_id;
	logic [wstd_pkg::ORIGIN_W-1:0]   origin;
	logic [wstd_pkg::VICTIM_W-1:0]   victim;

	modport source (output valid, ok, task_id, origin, victim, input ready);
	modport sink (input valid, ok, task_id, origin, victim, output ready);
endinterface
`default_nettype wire

>>> sv/work_stealing_task_dispatcher.sv
// A post or a fetch from the own deque passes from idle through the check state to the emit state,
// which loads the registered result beat; a fetch that steals or falls back to the overflow FIFO also
// scans each active worker in turn, then the FIFO, through the single shared pointer and fill compare unit.
// A new beat is taken only in the idle state, so one beat is finished before the next is accepted.
// Reset clears every deque and FIFO pointer and sets the active count to eight; the task stores
// keep their contents, so no clearing pass follows reset.
`default_nettype none
module work_stealing_task_dispatcher #(
	parameter int WORKERS        = wstd_pkg::WORKERS_DEF,
	parameter int DEQUE_DEPTH    = wstd_pkg::DEQUE_DEPTH_DEF,
	parameter int OVERFLOW_DEPTH = wstd_pkg::OVERFLOW_DEPTH_DEF,
	parameter int ID_WIDTH       = wstd_pkg::ID_WIDTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [wstd_pkg::AW_W-1:0] cfg_data,
	wstd_in_if.sink                        in_ch,
	wstd_out_if.source                     out_ch
);

	localparam int NW   = $clog2(WORKERS + 1);
	localparam int WI_W = $clog2(WORKERS);
	localparam int PW   = $clog2(2 * DEQUE_DEPTH);
	localparam int SW   = $clog2(DEQUE_DEPTH);
	localparam int OW   = $clog2(OVERFLOW_DEPTH);

	logic [wstd_pkg::AW_W-1:0] aw_q;
	logic [NW-1:0]             n_c;
	logic                      w_ok_c;

	wstd_pkg::state_t state_q, state_d;

	logic               cmd_q;
	logic [WI_W-1:0]    w_idx_q;
	logic               w_ok_q;
	logic [NW-1:0]      n_q;
	logic [ID_WIDTH-1:0] id_q;
	logic [NW-1:0]      scan_q;

	logic [PW-1:0] top_q [WORKERS];
	logic [PW-1:0] bot_q [WORKERS];
	logic [OW-1:0] head_q;
	logic [OW-1:0] tail_q;

	logic [ID_WIDTH-1:0] dq_mem [WORKERS][DEQUE_DEPTH];
	logic [ID_WIDTH-1:0] ovf_mem [OVERFLOW_DEPTH];
	logic [ID_WIDTH-1:0] dq_rd_q;
	logic [ID_WIDTH-1:0] ovf_rd_q;

	logic                         res_ok_q, res_ok_d;
	logic [wstd_pkg::ORIGIN_W-1:0] res_origin_q, res_origin_d;
	logic [wstd_pkg::VICTIM_W-1:0] res_victim_q, res_victim_d;
	wstd_pkg::src_t               res_src_q, res_src_d;
	logic                         res_load;

	logic                         out_valid_q;
	logic                         out_ok_q;
	logic [wstd_pkg::ID_FIELD_W-1:0] out_task_q;
	logic [wstd_pkg::ORIGIN_W-1:0]   out_origin_q;
	logic [wstd_pkg::VICTIM_W-1:0]   out_victim_q;
	logic                         emit;

	logic [WI_W-1:0] sel_idx;
	logic [PW-1:0]   sel_top, sel_bot, sel_fill, bot_inc, bot_dec, top_inc;
	logic [PW:0]     fill_diff;
	logic            sel_nonempty, sel_room;
	logic            ovf_empty, ovf_full;
	logic [OW-1:0]   head_inc, tail_inc;

	logic            dq_we, dq_re, top_we, bot_we, ovf_we, ovf_re;
	logic [SW-1:0]   dq_slot;
	logic [PW-1:0]   bot_new;
	logic            scan_clr, scan_inc;

	function automatic logic [SW-1:0] slot_of(input logic [PW-1:0] pos);
		logic [PW-1:0] s;
		s = (pos >= PW'(DEQUE_DEPTH)) ? pos - PW'(DEQUE_DEPTH) : pos;
		return s[SW-1:0];
	endfunction

	always_comb begin
		if (aw_q == '0) begin
			n_c = NW'(1);
		end else if (32'(aw_q) > 32'(WORKERS)) begin
			n_c = NW'(WORKERS);
		end else begin
			n_c = NW'(aw_q);
		end
		w_ok_c = 32'(in_ch.worker) < 32'(n_c);
	end

	assign sel_idx   = (state_q == wstd_pkg::ST_CHECK) ? w_idx_q : scan_q[WI_W-1:0];
	assign sel_top   = top_q[sel_idx];
	assign sel_bot   = bot_q[sel_idx];
	assign fill_diff = {1'b0, sel_bot} - {1'b0, sel_top};
	assign sel_fill  = fill_diff[PW] ? PW'(fill_diff + (PW + 1)'(2 * DEQUE_DEPTH))
	                                 : fill_diff[PW-1:0];
	assign sel_nonempty = sel_fill != '0;
	assign sel_room     = sel_fill < PW'(DEQUE_DEPTH - 1);
	assign bot_inc = (sel_bot == PW'(2 * DEQUE_DEPTH - 1)) ? '0 : sel_bot + 1'b1;
	assign bot_dec = (sel_bot == '0) ? PW'(2 * DEQUE_DEPTH - 1) : sel_bot - 1'b1;
	assign top_inc = (sel_top == PW'(2 * DEQUE_DEPTH - 1)) ? '0 : sel_top + 1'b1;

	assign head_inc  = (head_q == OW'(OVERFLOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_inc  = (tail_q == OW'(OVERFLOW_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign ovf_empty = head_q == tail_q;
	assign ovf_full  = tail_inc == head_q;

	assign in_ch.ready = state_q == wstd_pkg::ST_IDLE;

	always_comb begin
		state_d      = state_q;
		dq_we        = 1'b0;
		dq_re        = 1'b0;
		top_we       = 1'b0;
		bot_we       = 1'b0;
		ovf_we       = 1'b0;
		ovf_re       = 1'b0;
		dq_slot      = slot_of(sel_top);
		bot_new      = bot_inc;
		scan_clr     = 1'b0;
		scan_inc     = 1'b0;
		res_load     = 1'b0;
		res_ok_d     = 1'b0;
		res_origin_d = wstd_pkg::ORG_NONE;
		res_victim_d = '0;
		res_src_d    = wstd_pkg::SRC_NONE;
		emit         = 1'b0;
		unique case (state_q)
			wstd_pkg::ST_IDLE: begin
				if (in_ch.valid) begin
					state_d = wstd_pkg::ST_CHECK;
				end
			end
			wstd_pkg::ST_CHECK: begin
				res_load = 1'b1;
				state_d  = wstd_pkg::ST_EMIT;
				if (!w_ok_q) begin
					res_origin_d = wstd_pkg::ORG_BAD;
				end else if (cmd_q == wstd_pkg::CMD_POST) begin
					if (sel_room) begin
						dq_we        = 1'b1;
						dq_slot      = slot_of(sel_bot);
						bot_we       = 1'b1;
						bot_new      = bot_inc;
						res_ok_d     = 1'b1;
						res_origin_d = wstd_pkg::ORG_DEQUE;
					end else if (!ovf_full) begin
						ovf_we       = 1'b1;
						res_ok_d     = 1'b1;
						res_origin_d = wstd_pkg::ORG_OVERFLOW;
					end else begin
						res_origin_d = wstd_pkg::ORG_FULL;
					end
				end else if (sel_nonempty) begin
					dq_re        = 1'b1;
					dq_slot      = slot_of(bot_dec);
					bot_we       = 1'b1;
					bot_new      = bot_dec;
					res_ok_d     = 1'b1;
					res_origin_d = wstd_pkg::ORG_OWN;
					res_src_d    = wstd_pkg::SRC_DEQUE;
				end else begin
					res_load = 1'b0;
					scan_clr = 1'b1;
					state_d  = wstd_pkg::ST_SCAN;
				end
			end
			wstd_pkg::ST_SCAN: begin
				if (scan_q < n_q) begin
					if (scan_q[WI_W-1:0] != w_idx_q && sel_nonempty) begin
						dq_re        = 1'b1;
						dq_slot      = slot_of(sel_top);
						top_we       = 1'b1;
						res_load     = 1'b1;
						res_ok_d     = 1'b1;
						res_origin_d = wstd_pkg::ORG_STOLEN;
						res_victim_d = wstd_pkg::VICTIM_W'(scan_q);
						res_src_d    = wstd_pkg::SRC_DEQUE;
						state_d      = wstd_pkg::ST_EMIT;
					end else begin
						scan_inc = 1'b1;
					end
				end else begin
					res_load = 1'b1;
					state_d  = wstd_pkg::ST_EMIT;
					if (!ovf_empty) begin
						ovf_re       = 1'b1;
						res_ok_d     = 1'b1;
						res_origin_d = wstd_pkg::ORG_FIFO;
						res_src_d    = wstd_pkg::SRC_FIFO;
					end
				end
			end
			wstd_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ch.ready) begin
					emit    = 1'b1;
					state_d = wstd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wstd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wstd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aw_q <= wstd_pkg::AW_RESET;
		end else if (cfg_we) begin
			aw_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			cmd_q   <= in_ch.command;
			w_idx_q <= WI_W'(in_ch.worker);
			w_ok_q  <= w_ok_c;
			n_q     <= n_c;
			id_q    <= ID_WIDTH'(in_ch.post_id);
		end
		if (scan_clr) begin
			scan_q <= '0;
		end else if (scan_inc) begin
			scan_q <= scan_q + 1'b1;
		end
		if (res_load) begin
			res_ok_q     <= res_ok_d;
			res_origin_q <= res_origin_d;
			res_victim_q <= res_victim_d;
			res_src_q    <= res_src_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WORKERS; i++) begin
				top_q[i] <= '0;
				bot_q[i] <= '0;
			end
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (top_we) begin
				top_q[sel_idx] <= top_inc;
			end
			if (bot_we) begin
				bot_q[sel_idx] <= bot_new;
			end
			if (ovf_re) begin
				head_q <= head_inc;
			end
			if (ovf_we) begin
				tail_q <= tail_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dq_we) begin
			dq_mem[sel_idx][dq_slot] <= id_q;
		end
		if (dq_re) begin
			dq_rd_q <= dq_mem[sel_idx][dq_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (ovf_we) begin
			ovf_mem[tail_q] <= id_q;
		end
		if (ovf_re) begin
			ovf_rd_q <= ovf_mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_ok_q     <= res_ok_q;
			out_origin_q <= res_origin_q;
			out_victim_q <= res_victim_q;
			unique case (res_src_q)
				wstd_pkg::SRC_DEQUE: out_task_q <= wstd_pkg::ID_FIELD_W'(dq_rd_q);
				wstd_pkg::SRC_FIFO:  out_task_q <= wstd_pkg::ID_FIELD_W'(ovf_rd_q);
				default:             out_task_q <= '0;
			endcase
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.ok      = out_ok_q;
	assign out_ch.task_id = out_task_q;
	assign out_ch.origin  = out_origin_q;
	assign out_ch.victim  = out_victim_q;

	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> (state_q == wstd_pkg::ST_CHECK))
		else $error("accepted beat did not start a check");

	a_deque_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wstd_pkg::ST_CHECK) |-> (sel_fill <= PW'(DEQUE_DEPTH - 1)))
		else $error("deque fill above its capacity");

	a_fifo_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_we |-> (!ovf_full && !ovf_re))
		else $error("overflow FIFO written while full");

	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == wstd_pkg::ST_EMIT))
		else $error("result beat raised outside the emit step");

endmodule
`default_nettype wire
